// ===== rtl/bbv_pkg.sv =====
package bbv_pkg;

  localparam int MAX_SIDE_DEF   = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // image_side config register
  localparam int                CFG_W      = 11;
  localparam logic [CFG_W-1:0]  SIDE_RESET = CFG_W'(3);
  localparam int                MIN_SIDE   = 3;

  localparam int WIN = 3;

  // control that travels with a window sum down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } bbv_stage_t;

endpackage

// ===== rtl/bbv_cfg_if.sv =====
interface bbv_cfg_if
  import bbv_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] image_side;

  modport source (output valid, output image_side, input ready);
  modport sink   (input valid, input image_side, output ready);
endinterface

// ===== rtl/bbv_in_if.sv =====
interface bbv_in_if
  import bbv_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== rtl/bbv_out_if.sv =====
interface bbv_out_if
  import bbv_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [PIXEL_BITS+3:0]   window_sum;
  logic [PIXEL_BITS+7:0]   mean_q8_8;
  logic                    last_of_frame;

  modport source (output valid, output window_sum, output mean_q8_8,
                  output last_of_frame, input ready);
  modport sink   (input valid, input window_sum, input mean_q8_8,
                  input last_of_frame, output ready);
endinterface

// ===== rtl/box_blur_3x3_valid.sv =====
// 3x3 box filter over the valid region of a square image.
// in_if:  one pixel per request, raster order, row by row, valid/ready.
// out_if: one request per window whose bottom-right pixel lies at row >= 2 and
//         column >= 2: window_sum, mean_q8_8 = (sum*256+4)/9, last_of_frame on the
//         final result of the image. (N-2)*(N-2) results per N*N pixels.
// cfg_if: image_side write, always ready; write it only while the block is idle.
//         Values outside 3..MAX_SIDE are clamped. Counters wrap so frames follow
//         back to back.
// A pixel passes stage A (line RAM read), the window sum and the mean registers.
// Throughput: one pixel per cycle while out_if is not stalled, with the single line
// RAM read at the current column and written back from stage A in each such cycle.
// Stall: out_if holds its request while ready is low; in_if keeps accepting
// until the two internal stages behind the output register are full, then
// in_if.ready drops; it comes back in the same cycle as out_if.ready (combinational).
// Reset: column/row counters and window clear, image_side returns to 3. Line RAM
// contents are not cleared; rows 0 and 1 of each frame fill it before any
// result uses it.
module box_blur_3x3_valid
  import bbv_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bbv_cfg_if.sink   cfg_if,
  bbv_in_if.sink    in_if,
  bbv_out_if.source out_if
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam logic [SW-1:0] SIDE_MIN = SW'(MIN_SIDE);
  localparam logic [SW-1:0] SIDE_MAX = SW'(MAX_SIDE);
  localparam int SUMW = PIXEL_BITS + 4;

  logic [CFG_W-1:0]      image_side_r;
  logic [SW-1:0]         side_raw;
  logic [SW-1:0]         side;

  logic [CW-1:0]         col_r, col_nxt;
  logic [CW-1:0]         row_r, row_nxt;
  logic                  row_end, frame_end, is_res;
  logic                  accept;

  logic                  valid_a_r;
  logic [CW-1:0]         addr_a_r;
  logic [PIXEL_BITS-1:0] px_a_r;
  logic                  res_a_r;
  logic                  last_a_r;
  logic                  en_a, en_b, take;

  logic                    ram_re, ram_we;
  logic [2*PIXEL_BITS-1:0] ram_rdata;
  logic [2*PIXEL_BITS-1:0] ram_wdata;

  bbv_stage_t            a_ctl, b_ctl;
  logic [SUMW-1:0]       sum_b;

  // config
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_side_r <= SIDE_RESET;
    end else if (cfg_if.valid) begin
      image_side_r <= cfg_if.image_side;
    end
  end

  assign side_raw = SW'(image_side_r);

  always_comb begin
    priority if (side_raw < SIDE_MIN) begin
      side = SIDE_MIN;
    end else if (side_raw > SIDE_MAX) begin
      side = SIDE_MAX;
    end else begin
      side = side_raw;
    end
  end

  // position counters
  assign accept    = in_if.valid && in_if.ready;
  assign row_end   = (SW'(col_r) + SW'(1)) >= side;
  assign frame_end = row_end && ((SW'(row_r) + SW'(1)) >= side);
  assign is_res    = (row_r >= CW'(2)) && (col_r >= CW'(2));

  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = frame_end ? '0 : row_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage A: line RAM read in flight
  assign en_a        = !valid_a_r || en_b;
  assign in_if.ready = en_a;
  assign en_b        = !b_ctl.valid || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (en_a) begin
      valid_a_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_a_r <= col_r;
      px_a_r   <= in_if.pixel;
      res_a_r  <= is_res;
      last_a_r <= frame_end;
    end
  end

  // RAM word: upper half is the row two back, lower half the previous row.
  // Write-back comes from stage A, at the column of the pixel held there, the
  // previous column, so a read never meets a write to the same entry.
  assign ram_re    = accept;
  assign ram_we    = valid_a_r && en_b;
  assign ram_wdata = {ram_rdata[PIXEL_BITS-1:0], px_a_r};

  bbv_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_SIDE)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_a_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign a_ctl.valid = valid_a_r && res_a_r;
  assign a_ctl.last  = last_a_r;

  bbv_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (ram_we),
    .load_en  (en_b),
    .a_ctl    (a_ctl),
    .top      (ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS]),
    .mid      (ram_rdata[PIXEL_BITS-1:0]),
    .px       (px_a_r),
    .b_ctl    (b_ctl),
    .sum_b    (sum_b)
  );

  bbv_mean #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mean (
    .clk    (clk),
    .rst_n  (rst_n),
    .b_ctl  (b_ctl),
    .sum_b  (sum_b),
    .take   (take),
    .out_if (out_if)
  );

`ifndef SYNTHESIS
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_end) |=> (col_r == '0 && row_r == '0))
    else $error("counters did not wrap at frame end");

  a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re && ram_we) |-> (col_r != addr_a_r))
    else $error("line RAM read and write-back hit the same entry");

  a_stage_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_a_r && !en_a) |=> (valid_a_r && $stable(addr_a_r) && $stable(ram_rdata)))
    else $error("stalled line RAM stage lost its pixel");
`endif

endmodule

// ===== rtl/bbv_ram.sv =====
module bbv_ram
  import bbv_pkg::*;
#(
  parameter int   WIDTH = 2 * PIXEL_BITS_DEF,
  parameter int   DEPTH = MAX_SIDE_DEF,
  localparam int  AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bbv_window.sv =====
module bbv_window
  import bbv_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic                  load_en,
  input  bbv_stage_t            a_ctl,
  input  logic [PIXEL_BITS-1:0] top,
  input  logic [PIXEL_BITS-1:0] mid,
  input  logic [PIXEL_BITS-1:0] px,
  output bbv_stage_t            b_ctl,
  output logic [PIXEL_BITS+3:0] sum_b
);

  localparam int SUMW = PIXEL_BITS + 4;

  logic [PIXEL_BITS-1:0] win_r [WIN][WIN];
  bbv_stage_t            b_ctl_r;
  logic [SUMW-1:0]       sum_r;
  logic [SUMW-1:0]       sum_nxt;

  // sum of the window as it stands after this shift: old columns 1, 2 plus new column
  always_comb begin
    sum_nxt = SUMW'(top) + SUMW'(mid) + SUMW'(px);
    for (int i = 0; i < WIN; i++) begin
      sum_nxt = sum_nxt + SUMW'(win_r[i][1]) + SUMW'(win_r[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (shift_en) begin
      for (int i = 0; i < WIN; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= top;
      win_r[1][2] <= mid;
      win_r[2][2] <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
    end else if (load_en) begin
      b_ctl_r <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && a_ctl.valid) begin
      sum_r <= sum_nxt;
    end
  end

  assign b_ctl = b_ctl_r;
  assign sum_b = sum_r;

endmodule

// ===== rtl/bbv_mean.sv =====
module bbv_mean
  import bbv_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bbv_stage_t            b_ctl,
  input  logic [PIXEL_BITS+3:0] sum_b,
  output logic                  take,
  bbv_out_if.source             out_if
);

  localparam int SUMW  = PIXEL_BITS + 4;
  localparam int XW    = SUMW + 8;
  localparam int K     = XW + 3;
  localparam int MEANW = PIXEL_BITS + 8;
  localparam int PW    = 2 * XW + 1;
  // ceil(2^K / 9); error term below 9, so x * RECIP >> K is exact for x < 2^XW
  localparam logic [XW:0] RECIP = (XW + 1)'(((64'd1 << K) + 64'd8) / 64'd9);

  logic [XW-1:0]    x;
  logic [PW-1:0]    prod;
  logic             out_valid_r;
  logic             last_r;
  logic [SUMW-1:0]  sum_r;
  logic [MEANW-1:0] mean_r;

  // sum * 256 + 4
  assign x    = {sum_b, 8'h04};
  assign prod = PW'(x) * PW'(RECIP);
  assign take = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= b_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && b_ctl.valid) begin
      sum_r  <= sum_b;
      mean_r <= prod[K +: MEANW];
      last_r <= b_ctl.last;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.window_sum    = sum_r;
  assign out_if.mean_q8_8     = mean_r;
  assign out_if.last_of_frame = last_r;

endmodule
